/* src/assert_macros.svh */
// Assertion macros shared by the stack controller and datapath.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LSSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lssd assertion failed");

// Condition must never be true at a clock edge outside reset.
`define LSSD_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lssd forbidden condition seen");

`endif

/* src/lssd_pkg.sv */
// Shared types and constants for the LIFO stack with search and delete.
// No dependencies; used by lssd_ctrl, lssd_dpath and the top level.
`timescale 1ns / 1ps

package lssd_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_DUMP   = 2'd3
  } lssd_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } lssd_status_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] id_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] entry_value;
    logic               last;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic         start_down;  // walk from top entry toward bottom
    logic         start_up;    // walk from just above the hit toward top
    logic         abort;       // stop the walk
    logic         push;        // write item at fill, bump fill
    logic         dec_fill;    // drop one entry
    logic         emit;        // present a result next cycle
    lssd_status_t status;
    logic         use_entry;   // result carries the read entry
    logic         last;
  } lssd_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic rd_vld;   // read data valid this cycle
    logic rd_last;  // read data is the final one of the walk
    logic hit;      // read data equals the held identifier
    logic hit_top;  // hit is the topmost entry
  } lssd_stat_t;

endpackage

/* src/lssd_ctrl.sv */
// Controller state machine for the LIFO stack with search and delete.
// Depends on lssd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lssd_ctrl
  import lssd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  lssd_op_t   in_op,
  input  lssd_stat_t stat,
  output lssd_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DUMP
  } state_t;

  state_t   state_r, state_nxt;
  lssd_op_t op_r, op_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = in_op;
          priority if (in_op == OP_PUSH) begin
            cmd.emit   = 1'b1;
            cmd.last   = 1'b1;
            cmd.push   = !stat.full;
            cmd.status = stat.full ? ST_FULL : ST_OK;
          end else if (stat.empty) begin
            cmd.emit   = 1'b1;
            cmd.last   = 1'b1;
            cmd.status = ST_EMPTY;
          end else begin
            cmd.start_down = 1'b1;
            state_nxt = (in_op == OP_DUMP) ? S_DUMP : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        priority if (stat.hit) begin
          cmd.abort = 1'b1;
          priority if (op_r == OP_SEARCH) begin
            cmd.emit  = 1'b1;
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end else if (stat.hit_top) begin
            cmd.dec_fill = 1'b1;
            cmd.emit     = 1'b1;
            cmd.last     = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            cmd.start_up = 1'b1;
            state_nxt    = S_SHIFT;
          end
        end else if (stat.rd_vld && stat.rd_last) begin
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          cmd.status = ST_NOT_FOUND;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SHIFT: begin
        if (stat.rd_vld && stat.rd_last) begin
          cmd.dec_fill = 1'b1;
          cmd.emit     = 1'b1;
          cmd.last     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DUMP: begin
        if (stat.rd_vld) begin
          cmd.emit      = 1'b1;
          cmd.use_entry = 1'b1;
          cmd.last      = stat.rd_last;
          if (stat.rd_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_PUSH;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Leaving a walk always hands out the final result of the item.
  `LSSD_ASSERT(a_busy_ends_with_last, $fell(busy) |-> $past(cmd.emit && cmd.last))
  // A walk never starts over an empty store.
  `LSSD_NEVER(a_no_walk_when_empty, cmd.start_down && stat.empty)

endmodule

/* src/lssd_dpath.sv */
// Datapath for the LIFO stack: entry memory, fill count, walk pointer,
// compare and result register. Depends on lssd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lssd_dpath
  import lssd_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  lssd_cmd_t  cmd,
  output lssd_stat_t stat,
  output logic       out_valid,
  output out_item_t  out_item
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [31:0]   mem [DEPTH];

  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          active_r, active_nxt;
  logic          dir_up_r, dir_up_nxt;
  logic          rd_vld_r;
  logic          rd_last_r;
  logic [AW-1:0] rd_addr_r;
  logic [31:0]   rd_data_r;
  logic [31:0]   id_r;
  logic          out_valid_r;
  out_item_t     out_item_r;

  logic [AW-1:0] top_addr;
  logic          issue;
  logic          issue_last;

  assign top_addr   = AW'(fill_r - CW'(1));
  assign issue      = active_r && !cmd.start_down && !cmd.start_up && !cmd.abort;
  assign issue_last = dir_up_r ? (ptr_r == top_addr) : (ptr_r == '0);

  always_comb begin
    ptr_nxt    = ptr_r;
    active_nxt = active_r;
    dir_up_nxt = dir_up_r;
    fill_nxt   = fill_r;
    priority if (cmd.start_down) begin
      ptr_nxt    = top_addr;
      active_nxt = 1'b1;
      dir_up_nxt = 1'b0;
    end else if (cmd.start_up) begin
      ptr_nxt    = rd_addr_r + AW'(1);
      active_nxt = 1'b1;
      dir_up_nxt = 1'b1;
    end else if (cmd.abort) begin
      active_nxt = 1'b0;
    end else if (issue) begin
      ptr_nxt    = dir_up_r ? ptr_r + AW'(1) : ptr_r - AW'(1);
      active_nxt = !issue_last;
    end else begin
      active_nxt = active_r;
    end
    priority if (cmd.push) begin
      fill_nxt = fill_r + CW'(1);
    end else if (cmd.dec_fill) begin
      fill_nxt = fill_r - CW'(1);
    end else begin
      fill_nxt = fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      active_r    <= 1'b0;
      dir_up_r    <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      active_r    <= active_nxt;
      dir_up_r    <= dir_up_nxt;
      rd_vld_r    <= issue;
      out_valid_r <= cmd.emit;
    end
  end

  // Payload and pointer registers, no reset.
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.start_down) begin
      id_r <= in_item.id_value;
    end
    if (issue) begin
      rd_addr_r <= ptr_r;
      rd_last_r <= issue_last;
    end
    out_item_r.status      <= cmd.status;
    out_item_r.entry_value <= cmd.use_entry ? rd_data_r : '0;
    out_item_r.last        <= cmd.last;
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[fill_r[AW-1:0]] <= in_item.id_value;
    end else if (rd_vld_r && dir_up_r) begin
      mem[rd_addr_r - AW'(1)] <= rd_data_r;
    end
    if (issue) begin
      rd_data_r <= mem[ptr_r];
    end
  end

  assign stat.full    = (fill_r == CW'(DEPTH));
  assign stat.empty   = (fill_r == '0);
  assign stat.rd_vld  = rd_vld_r;
  assign stat.rd_last = rd_last_r;
  assign stat.hit     = rd_vld_r && (rd_data_r == id_r);
  assign stat.hit_top = ((CW'(rd_addr_r) + CW'(1)) == fill_r);

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `LSSD_NEVER(a_fill_in_range, fill_r > CW'(DEPTH))
  `LSSD_NEVER(a_push_only_below_full, cmd.push && stat.full)
  `LSSD_NEVER(a_read_below_fill, issue && (CW'(ptr_r) >= fill_r))

endmodule

/* src/lifo_stack_search_delete.sv */
// Top level of the bounded LIFO stack with search and delete by value.
// Depends on lssd_pkg, lssd_ctrl and lssd_dpath.
//
//   channel  ports                      handshake
//   -------  -------------------------  -------------------------------------
//   input    in_item (cmd, id_value)    taken when start is high, busy is low
//   result   out_item (status,          out_valid strobe with each result,
//            entry_value, last)         cannot be held off
//
// Push, and any command on an empty store, starts no walk; the result shows
// the cycle after and busy stays low, so the next item may follow at once.
// Search walks the entries top down through the single read port of the entry
// memory, one per cycle. Delete adds a shift of the entries above the hit, one
// per cycle; the longest delete is one whose only match is the bottom entry.
// Dump gives one result per cycle, each behind the registered memory read.
// Reset (rst_n low, synchronous) empties the store; entries are not cleared.
`timescale 1ns / 1ps

module lifo_stack_search_delete
  import lssd_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  lssd_cmd_t  cmd;
  lssd_stat_t stat;

  // Sequence each item: pick the walk, watch compares, drive results.
  lssd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (lssd_op_t'(in_item.cmd)),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold entries and fill count, walk the memory, register each result.
  lssd_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* bench/testbench.sv */
// Self-checking bench for the bounded LIFO stack with search and delete.
// Needs lssd_pkg and the lifo_stack_search_delete RTL; a shadow stack predicts
// every result, and a directed table runs ahead of weighted random traffic.
`timescale 1ns / 1ps

module testbench;
  import lssd_pkg::*;

  localparam int unsigned DEPTH     = DEPTH_DEF;
  localparam int          DIR_ROWS  = 25;
  localparam int          RAND_ITEMS = 100;  // items per random phase
  localparam int          DRAIN_CAP = 2000;  // cycles allowed for the tail to drain
  localparam int          SETTLE    = 2 * DEPTH + 8;  // longest delete walk, plus slack

  // One directed row: an item repeated reps times; typed rows carry the
  // status that follows at a glance, the rest take it from the shadow stack.
  typedef struct packed {
    lssd_op_t     op;
    logic [31:0]  id;
    logic [4:0]   reps;
    logic         typed;
    lssd_status_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  // Typed expectation that travels with the item on the input ports.
  logic         row_typed;
  lssd_status_t row_want;

  // Shadow stack: index 0 is the bottom, shadow_fill entries are valid.
  logic [31:0] shadow_entries [DEPTH];
  int unsigned shadow_fill;
  out_item_t   expected_results [$];
  int          mismatch_count;

  lifo_stack_search_delete #(.DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Report the first ten mismatches in full; count the rest silently.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Apply one accepted item to the shadow stack and queue what it must give.
  // Single-result commands collect their status first so a typed row can
  // stand in for it; a dump of a non-empty stack queues one result per entry.
  function automatic void stack_apply(input lssd_op_t op, input logic [31:0] id,
                                      input logic typed, input lssd_status_t want);
    int           hit;
    lssd_status_t st;
    out_item_t    res;
    hit = -1;
    st  = ST_OK;
    if (op == OP_PUSH) begin
      if (shadow_fill >= DEPTH) begin
        st = ST_FULL;
      end else begin
        shadow_entries[shadow_fill] = id;
        shadow_fill++;
      end
    end else if (shadow_fill == 0) begin
      st = ST_EMPTY;
    end else if (op == OP_DUMP) begin
      for (int i = int'(shadow_fill) - 1; i >= 0; i--) begin
        res.status      = ST_OK;
        res.entry_value = shadow_entries[i];
        res.last        = (i == 0);
        expected_results.push_back(res);
      end
      return;
    end else begin
      // Topmost match wins; compare on all 32 bits.
      for (int i = int'(shadow_fill) - 1; i >= 0; i--) begin
        if (hit < 0 && shadow_entries[i] == id) hit = i;
      end
      if (hit < 0) begin
        st = ST_NOT_FOUND;
      end else if (op == OP_DELETE) begin
        // Close the gap and keep the order of everything above the hit.
        for (int i = hit; i + 1 < int'(shadow_fill); i++) begin
          shadow_entries[i] = shadow_entries[i + 1];
        end
        shadow_fill--;
      end
    end
    res.status      = typed ? want : st;
    res.entry_value = '0;
    res.last        = 1'b1;
    expected_results.push_back(res);
  endfunction

  // Sample at the rising edge: check any result against the oldest
  // expectation first, then predict for an item accepted at this edge.
  always @(posedge clk) begin : scoreboard
    out_item_t w;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: status %0d value %0d last %0b",
                                    out_item.status, out_item.entry_value, out_item.last));
        end else begin
          w = expected_results.pop_front();
          if (out_item.status !== w.status)
            report_mismatch($sformatf("status expected %0d got %0d",
                                      w.status, out_item.status));
          if (out_item.entry_value !== w.entry_value)
            report_mismatch($sformatf("entry_value expected %0d got %0d",
                                      w.entry_value, out_item.entry_value));
          if (out_item.last !== w.last)
            report_mismatch($sformatf("last expected %0b got %0b", w.last, out_item.last));
        end
      end
      if (start && !busy) begin
        stack_apply(lssd_op_t'(in_item.cmd), in_item.id_value, row_typed, row_want);
      end
    end
  end

  // Present one item at the falling edge and hold it until an edge takes it.
  // Start stays high into the next item when no gap follows.
  task automatic send_item(input lssd_op_t op, input logic [31:0] id,
                           input logic typed, input lssd_status_t want);
    @(negedge clk);
    start     <= 1'b1;
    in_item   <= {op, id};
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for the whole gap and scramble the item so the block must ignore it.
  task automatic idle_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      start   <= 1'b0;
      in_item <= {2'($urandom_range(3)), 32'($urandom)};
    end
  endtask

  // Pick an identifier: mostly live entries for delete and search so that
  // hits are common, a small pool for pushes so duplicates build up, and
  // full-range noise for the rest.
  function automatic logic [31:0] pick_id(input lssd_op_t op);
    logic [31:0] pool [8];
    int          r;
    pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h0000_0001, 32'h1234_5678, 32'hA5A5_5A5A, 32'h0000_8000};
    r = $urandom_range(99);
    if (op != OP_PUSH && shadow_fill > 0 && r < 60)
      return shadow_entries[$urandom_range(shadow_fill - 1)];
    if (r < 80)
      return pool[$urandom_range(7)];
    return $urandom;
  endfunction

  // Extremes, every command, empty, full, no match, topmost duplicate,
  // bottom delete and a one-bit miss.
  dir_row_t dir_table [DIR_ROWS] = '{
    '{OP_SEARCH, 32'h0000_0000, 5'd1,  1'b1, ST_EMPTY},
    '{OP_DELETE, 32'h0000_0005, 5'd1,  1'b1, ST_EMPTY},
    '{OP_DUMP,   32'h0000_0000, 5'd1,  1'b1, ST_EMPTY},
    '{OP_PUSH,   32'h7FFF_FFFF, 5'd1,  1'b1, ST_OK},
    '{OP_PUSH,   32'h8000_0000, 5'd1,  1'b1, ST_OK},
    '{OP_PUSH,   32'hFFFF_FFFF, 5'd1,  1'b1, ST_OK},
    '{OP_PUSH,   32'h0000_0000, 5'd1,  1'b1, ST_OK},
    '{OP_SEARCH, 32'h8000_0000, 5'd1,  1'b1, ST_OK},
    '{OP_SEARCH, 32'h0000_0001, 5'd1,  1'b1, ST_NOT_FOUND},
    '{OP_SEARCH, 32'h7FFF_FFFE, 5'd1,  1'b1, ST_NOT_FOUND},
    '{OP_DELETE, 32'h0001_2345, 5'd1,  1'b1, ST_NOT_FOUND},
    '{OP_DUMP,   32'hDEAD_BEEF, 5'd1,  1'b0, ST_OK},
    '{OP_PUSH,   32'hFFFF_FFFF, 5'd1,  1'b1, ST_OK},
    '{OP_DELETE, 32'hFFFF_FFFF, 5'd1,  1'b1, ST_OK},
    '{OP_DUMP,   32'h0000_0000, 5'd1,  1'b0, ST_OK},
    '{OP_DELETE, 32'h7FFF_FFFF, 5'd1,  1'b1, ST_OK},
    '{OP_DUMP,   32'hFFFF_FFFF, 5'd1,  1'b0, ST_OK},
    '{OP_PUSH,   32'hA5A5_5A5A, 5'd13, 1'b1, ST_OK},
    '{OP_PUSH,   32'h0000_0001, 5'd1,  1'b1, ST_FULL},
    '{OP_DUMP,   32'h0000_0000, 5'd1,  1'b0, ST_OK},
    '{OP_SEARCH, 32'h8000_0000, 5'd1,  1'b1, ST_OK},
    '{OP_DELETE, 32'h8000_0001, 5'd1,  1'b1, ST_NOT_FOUND},
    '{OP_DELETE, 32'h8000_0000, 5'd1,  1'b1, ST_OK},
    '{OP_SEARCH, 32'h8000_0000, 5'd1,  1'b1, ST_NOT_FOUND},
    '{OP_DUMP,   32'h0000_0000, 5'd1,  1'b0, ST_OK}
  };

  initial begin : stimulus
    // Sender idle percentage per phase. The receiver cannot stall results,
    // so the phases meant for it run with the sender alone.
    int idle_pct [4];
    int push_w;
    int r;
    int waited;
    lssd_op_t op;
    idle_pct       = '{0, 63, 0, 31};
    mismatch_count = 0;
    shadow_fill    = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_item        = '0;
    row_typed      = 1'b0;
    row_want       = ST_OK;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[k]) begin
      repeat (dir_table[k].reps) begin
        send_item(dir_table[k].op, dir_table[k].id, dir_table[k].typed, dir_table[k].want);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      push_w = 50;
      for (int n = 0; n < RAND_ITEMS; n++) begin
        // Swing the push weight every 25 items so the stack is pushed toward full
        // and toward empty within each phase.
        if (n % 25 == 0) push_w = 20 + 25 * $urandom_range(2);
        r = $urandom_range(99);
        if (r < push_w) op = OP_PUSH;
        else begin
          r = $urandom_range(3);
          op = (r < 2) ? OP_DELETE : (r == 2) ? OP_SEARCH : OP_DUMP;
        end
        if ($urandom_range(99) < idle_pct[ph]) idle_gap($urandom_range(1, SETTLE));
        send_item(op, pick_id(op), 1'b0, ST_OK);
      end
    end

    idle_gap(1);
    waited = 0;
    while (expected_results.size() != 0 && waited < DRAIN_CAP) begin
      @(posedge clk);
      waited++;
    end
    // Hold a little longer to catch any stray result.
    repeat (SETTLE) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", expected_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #3ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
